// ===== rtl/core/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite screen projection package
// Shared constants and register codes for the sprite projection core.
// ----------------------------------------------------------------------------
package ssp_pkg;

   // Fixed point fraction bits by default (Q16.16).
   localparam int FRAC_BITS_DEF = 16;

   // Quotient width of the divider pipelines.
   localparam int QUO_W = 32;

   // Screen dimension registers.
   localparam int           SCR_W       = 13;
   localparam logic [12:0]  WIDTH_RST   = 13'd640;
   localparam logic [12:0]  HEIGHT_RST  = 13'd480;

   // Saturation limits.
   localparam logic signed [31:0] INT_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INT_MIN  = 32'sh8000_0000;
   localparam logic [15:0]        SIZE_SAT = 16'hFFFF;

   // Register index codes on the configuration port.
   typedef enum logic {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } reg_index_type;

endpackage

// ===== rtl/core/ssp_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider, two dividends over one divisor
// One quotient bit per stage for each dividend; a sideband travels alongside.
// ----------------------------------------------------------------------------
module ssp_div_pipe
   import ssp_pkg::*;
#(
   parameter int DEN_W  = 64,
   parameter int Q_W    = QUO_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DEN_W-1:0]  in_rem_a,
   input  logic [Q_W-1:0]    in_low_a,
   input  logic [DEN_W-1:0]  in_rem_b,
   input  logic [Q_W-1:0]    in_low_b,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [Q_W-1:0]    out_quo_a,
   output logic [Q_W-1:0]    out_quo_b,
   output logic [SIDE_W-1:0] out_side
);

   logic [Q_W-1:0]    vld_ff;
   logic [Q_W-1:0]    vld_src;
   logic [Q_W:0]      rdy;
   logic [DEN_W-1:0]  rem_a_ff  [Q_W];
   logic [DEN_W-1:0]  rem_b_ff  [Q_W];
   logic [Q_W-1:0]    low_a_ff  [Q_W];
   logic [Q_W-1:0]    low_b_ff  [Q_W];
   logic [DEN_W-1:0]  den_ff    [Q_W];
   logic [SIDE_W-1:0] side_ff   [Q_W];
   logic [DEN_W-1:0]  rem_a_src [Q_W];
   logic [DEN_W-1:0]  rem_b_src [Q_W];
   logic [Q_W-1:0]    low_a_src [Q_W];
   logic [Q_W-1:0]    low_b_src [Q_W];
   logic [DEN_W-1:0]  den_src   [Q_W];
   logic [SIDE_W-1:0] side_src  [Q_W];
   logic [DEN_W:0]    trial_a   [Q_W];
   logic [DEN_W:0]    trial_b   [Q_W];
   logic [Q_W-1:0]    take_a;
   logic [Q_W-1:0]    take_b;
   logic [DEN_W-1:0]  rem_a_in  [Q_W];
   logic [DEN_W-1:0]  rem_b_in  [Q_W];
   logic [Q_W-1:0]    low_a_in  [Q_W];
   logic [Q_W-1:0]    low_b_in  [Q_W];

   // Each stage takes its operands from the stage before, the first from the inputs.
   always_comb begin
      vld_src[0]   = in_valid;
      rem_a_src[0] = in_rem_a;
      rem_b_src[0] = in_rem_b;
      low_a_src[0] = in_low_a;
      low_b_src[0] = in_low_b;
      den_src[0]   = in_den;
      side_src[0]  = in_side;
      for (int k = 1; k < Q_W; k++) begin
         vld_src[k]   = vld_ff[k-1];
         rem_a_src[k] = rem_a_ff[k-1];
         rem_b_src[k] = rem_b_ff[k-1];
         low_a_src[k] = low_a_ff[k-1];
         low_b_src[k] = low_b_ff[k-1];
         den_src[k]   = den_ff[k-1];
         side_src[k]  = side_ff[k-1];
      end
   end

   // One restoring step per stage: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      for (int k = 0; k < Q_W; k++) begin
         trial_a[k]  = {rem_a_src[k], low_a_src[k][Q_W-1]};
         trial_b[k]  = {rem_b_src[k], low_b_src[k][Q_W-1]};
         take_a[k]   = trial_a[k] >= {1'b0, den_src[k]};
         take_b[k]   = trial_b[k] >= {1'b0, den_src[k]};
         rem_a_in[k] = take_a[k] ? DEN_W'(trial_a[k] - {1'b0, den_src[k]})
                                 : trial_a[k][DEN_W-1:0];
         rem_b_in[k] = take_b[k] ? DEN_W'(trial_b[k] - {1'b0, den_src[k]})
                                 : trial_b[k][DEN_W-1:0];
         low_a_in[k] = {low_a_src[k][Q_W-2:0], take_a[k]};
         low_b_in[k] = {low_b_src[k][Q_W-2:0], take_b[k]};
      end
   end

   // A stage moves on when it is empty or the stage after it moves on.
   always_comb begin
      rdy[Q_W] = out_ready;
      for (int k = Q_W - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < Q_W; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      for (int k = 0; k < Q_W; k++) begin
         if (rdy[k]) begin
            rem_a_ff[k] <= rem_a_in[k];
            rem_b_ff[k] <= rem_b_in[k];
            low_a_ff[k] <= low_a_in[k];
            low_b_ff[k] <= low_b_in[k];
            den_ff[k]   <= den_src[k];
            side_ff[k]  <= side_src[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[Q_W-1];
   assign out_quo_a = low_a_ff[Q_W-1];
   assign out_quo_b = low_b_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// ===== rtl/core/sprite_screen_projection_core.sv =====
// ----------------------------------------------------------------------------
// Sprite screen projection core
// Carries a billboard sprite into camera space and gives its screen bounds.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input beat passes through two 32-stage divider pipelines and
// twelve stages of multiply and clamp logic on its way to its result beat.
// Throughput: one beat per cycle unless rsp_stall holds the result register; every
// stage holds a valid bit, and a stage with a bubble keeps moving during such a stall.
// Reset clears every valid bit and sets the screen size to 640 by 480.
module sprite_screen_projection_core
   import ssp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // Input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sprite_x,
   input  logic signed [31:0] req_sprite_y,
   input  logic signed [31:0] req_camera_x,
   input  logic signed [31:0] req_camera_y,
   input  logic signed [31:0] req_facing_x,
   input  logic signed [31:0] req_facing_y,
   input  logic signed [31:0] req_view_plane_x,
   input  logic signed [31:0] req_view_plane_y,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_depth,
   output logic signed [31:0] rsp_centre_column,
   output logic [15:0]        rsp_sprite_size,
   output logic [11:0]        rsp_first_column,
   output logic signed [16:0] rsp_end_column,
   output logic [11:0]        rsp_first_row,
   output logic [11:0]        rsp_end_row,
   output logic               rsp_drawable,
   // Configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic signed [33:0] HALF_CELL = 34'sd1 <<< (FRAC_BITS - 1);

   // Saturate a 34-bit sum to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) begin
         r = INT_MAX;
      end else if (v < -34'sd2147483648) begin
         r = INT_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Apply the sign to a quotient magnitude and saturate to 32 bits.
   function automatic logic signed [31:0] quo_sat(input logic [31:0] q,
                                                  input logic neg, input logic ovf);
      logic signed [31:0] r;
      if (!neg) begin
         r = (ovf || q[31]) ? INT_MAX : signed'(q);
      end else begin
         r = (ovf || (q > 32'h8000_0000)) ? INT_MIN : signed'(32'(-q));
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [12:0]   width_ff;
   logic [12:0]   height_ff;
   reg_index_type csr_index;
   logic          csr_write;
   logic [11:0]   half_width;
   logic [11:0]   half_height;

   assign csr_index   = reg_index_type'(csr_paddr[2]);
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready  = 1'b1;
   assign half_width  = width_ff[12:1];
   assign half_height = height_ff[12:1];

   // Screen size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  width_ff  <= csr_pwdata[12:0];
            REG_SCREEN_HEIGHT: height_ff <= csr_pwdata[12:0];
            default:           ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         REG_SCREEN_WIDTH:  csr_prdata = 32'(width_ff);
         REG_SCREEN_HEIGHT: csr_prdata = 32'(height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- ready chain
   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, rdy_h, rdy_i, rdy_j;
   logic rdy_k, rdy_l;
   logic vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff, vld_e_ff, vld_f_ff, vld_g_ff;
   logic vld_h_ff, vld_i_ff, vld_j_ff, vld_k_ff, vld_l_ff;
   logic d1_in_ready, d1_out_valid, d2_in_ready, d2_out_valid;

   // A stage moves on when it is empty or the stage after it moves on.
   assign rdy_l = !vld_l_ff || !rsp_stall;
   assign rdy_k = !vld_k_ff || rdy_l;
   assign rdy_j = !vld_j_ff || d2_in_ready;
   assign rdy_i = !vld_i_ff || rdy_j;
   assign rdy_h = !vld_h_ff || rdy_i;
   assign rdy_g = !vld_g_ff || rdy_h;
   assign rdy_f = !vld_f_ff || rdy_g;
   assign rdy_e = !vld_e_ff || d1_in_ready;
   assign rdy_d = !vld_d_ff || rdy_e;
   assign rdy_c = !vld_c_ff || rdy_d;
   assign rdy_b = !vld_b_ff || rdy_c;
   assign rdy_a = !vld_a_ff || rdy_b;
   assign req_stall = !rdy_a;

   // Valid bits of the stages outside the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
         vld_e_ff <= 1'b0;
         vld_f_ff <= 1'b0;
         vld_g_ff <= 1'b0;
         vld_h_ff <= 1'b0;
         vld_i_ff <= 1'b0;
         vld_j_ff <= 1'b0;
         vld_k_ff <= 1'b0;
         vld_l_ff <= 1'b0;
      end else begin
         if (rdy_a) vld_a_ff <= req_valid;
         if (rdy_b) vld_b_ff <= vld_a_ff;
         if (rdy_c) vld_c_ff <= vld_b_ff;
         if (rdy_d) vld_d_ff <= vld_c_ff;
         if (rdy_e) vld_e_ff <= vld_d_ff;
         if (rdy_f) vld_f_ff <= d1_out_valid;
         if (rdy_g) vld_g_ff <= vld_f_ff;
         if (rdy_h) vld_h_ff <= vld_g_ff;
         if (rdy_i) vld_i_ff <= vld_h_ff;
         if (rdy_j) vld_j_ff <= vld_i_ff;
         if (rdy_k) vld_k_ff <= d2_out_valid;
         if (rdy_l) vld_l_ff <= vld_k_ff;
      end
   end

   // ---------------------------------------------------------------- stage A
   // Sprite offset from the camera plus half a cell, saturated.
   logic signed [31:0] sx_a_ff, sy_a_ff, dx_a_ff, dy_a_ff, px_a_ff, py_a_ff;
   logic signed [31:0] sx_a_in, sy_a_in;

   assign sx_a_in = sat32(34'(req_sprite_x) - 34'(req_camera_x) + HALF_CELL);
   assign sy_a_in = sat32(34'(req_sprite_y) - 34'(req_camera_y) + HALF_CELL);

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         sx_a_ff <= sx_a_in;
         sy_a_ff <= sy_a_in;
         dx_a_ff <= req_facing_x;
         dy_a_ff <= req_facing_y;
         px_a_ff <= req_view_plane_x;
         py_a_ff <= req_view_plane_y;
      end
   end

   // ---------------------------------------------------------------- stage B
   // Six products for the determinant and the two transform numerators.
   logic signed [63:0] pxdy_b_ff, dxpy_b_ff, dysx_b_ff, dxsy_b_ff, pxsy_b_ff, pysx_b_ff;
   logic signed [63:0] pxdy_b_in, dxpy_b_in, dysx_b_in, dxsy_b_in, pxsy_b_in, pysx_b_in;

   assign pxdy_b_in = 64'(px_a_ff) * 64'(dy_a_ff);
   assign dxpy_b_in = 64'(dx_a_ff) * 64'(py_a_ff);
   assign dysx_b_in = 64'(dy_a_ff) * 64'(sx_a_ff);
   assign dxsy_b_in = 64'(dx_a_ff) * 64'(sy_a_ff);
   assign pxsy_b_in = 64'(px_a_ff) * 64'(sy_a_ff);
   assign pysx_b_in = 64'(py_a_ff) * 64'(sx_a_ff);

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         pxdy_b_ff <= pxdy_b_in;
         dxpy_b_ff <= dxpy_b_in;
         dysx_b_ff <= dysx_b_in;
         dxsy_b_ff <= dxsy_b_in;
         pxsy_b_ff <= pxsy_b_in;
         pysx_b_ff <= pysx_b_in;
      end
   end

   // ---------------------------------------------------------------- stage C
   // Determinant and numerators, exact.
   logic signed [64:0] det_c_ff, numx_c_ff, numy_c_ff;

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         det_c_ff  <= 65'(pxdy_b_ff) - 65'(dxpy_b_ff);
         numx_c_ff <= 65'(dysx_b_ff) - 65'(dxsy_b_ff);
         numy_c_ff <= 65'(pxsy_b_ff) - 65'(pysx_b_ff);
      end
   end

   // ---------------------------------------------------------------- stage D
   // Magnitudes and quotient signs.
   logic [63:0] det_mag_d_ff, numx_mag_d_ff, numy_mag_d_ff;
   logic        negx_d_ff, negy_d_ff, det_zero_d_ff;
   logic [64:0] det_abs, numx_abs, numy_abs;

   assign det_abs  = det_c_ff[64]  ? 65'(-det_c_ff)  : 65'(det_c_ff);
   assign numx_abs = numx_c_ff[64] ? 65'(-numx_c_ff) : 65'(numx_c_ff);
   assign numy_abs = numy_c_ff[64] ? 65'(-numy_c_ff) : 65'(numy_c_ff);

   always_ff @(posedge clock) begin
      if (rdy_d) begin
         det_mag_d_ff  <= det_abs[63:0];
         numx_mag_d_ff <= numx_abs[63:0];
         numy_mag_d_ff <= numy_abs[63:0];
         negx_d_ff     <= numx_c_ff[64] ^ det_c_ff[64];
         negy_d_ff     <= numy_c_ff[64] ^ det_c_ff[64];
         det_zero_d_ff <= (det_c_ff == '0);
      end
   end

   // ---------------------------------------------------------------- stage E
   // Scale the numerators and split them into the divider's start remainder and
   // low bits; a start remainder not below the divisor means the quotient saturates.
   logic [95:0] numx_wide, numy_wide;
   logic [63:0] remx_e_ff, remy_e_ff, det_mag_e_ff;
   logic [31:0] lowx_e_ff, lowy_e_ff;
   logic        ovfx_e_ff, ovfy_e_ff, negx_e_ff, negy_e_ff, det_zero_e_ff;

   assign numx_wide = 96'(numx_mag_d_ff) << FRAC_BITS;
   assign numy_wide = 96'(numy_mag_d_ff) << FRAC_BITS;

   always_ff @(posedge clock) begin
      if (rdy_e) begin
         remx_e_ff     <= numx_wide[95:32];
         remy_e_ff     <= numy_wide[95:32];
         lowx_e_ff     <= numx_wide[31:0];
         lowy_e_ff     <= numy_wide[31:0];
         ovfx_e_ff     <= numx_wide[95:32] >= det_mag_d_ff;
         ovfy_e_ff     <= numy_wide[95:32] >= det_mag_d_ff;
         det_mag_e_ff  <= det_mag_d_ff;
         negx_e_ff     <= negx_d_ff;
         negy_e_ff     <= negy_d_ff;
         det_zero_e_ff <= det_zero_d_ff;
      end
   end

   // ---------------------------------------------------------------- transform divider
   logic [31:0] d1_quo_x, d1_quo_y;
   logic [4:0]  d1_side;

   ssp_div_pipe #(
      .DEN_W  (64),
      .Q_W    (QUO_W),
      .SIDE_W (5)
   ) u_div_transform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_e_ff),
      .in_ready  (d1_in_ready),
      .in_rem_a  (remx_e_ff),
      .in_low_a  (lowx_e_ff),
      .in_rem_b  (remy_e_ff),
      .in_low_b  (lowy_e_ff),
      .in_den    (det_mag_e_ff),
      .in_side   ({det_zero_e_ff, negx_e_ff, negy_e_ff, ovfx_e_ff, ovfy_e_ff}),
      .out_valid (d1_out_valid),
      .out_ready (rdy_f),
      .out_quo_a (d1_quo_x),
      .out_quo_b (d1_quo_y),
      .out_side  (d1_side)
   );

   // ---------------------------------------------------------------- stage F
   // Signed, saturated camera-space coordinates; both zero for a zero determinant.
   logic signed [31:0] tx_f_ff, ty_f_ff;
   logic               det_zero_f_ff;

   always_ff @(posedge clock) begin
      if (rdy_f) begin
         tx_f_ff       <= d1_side[4] ? '0 : quo_sat(d1_quo_x, d1_side[3], d1_side[1]);
         ty_f_ff       <= d1_side[4] ? '0 : quo_sat(d1_quo_y, d1_side[2], d1_side[0]);
         det_zero_f_ff <= d1_side[4];
      end
   end

   // ---------------------------------------------------------------- stage G
   logic signed [32:0] sum_g_ff;
   logic signed [31:0] ty_g_ff;
   logic [31:0]        ty_mag_g_ff;
   logic               ty_neg_g_ff, ty_zero_g_ff, drawable_g_ff;
   logic signed [32:0] ty_neg_wide;

   assign ty_neg_wide = -33'(ty_f_ff);

   always_ff @(posedge clock) begin
      if (rdy_g) begin
         sum_g_ff      <= 33'(tx_f_ff) + 33'(ty_f_ff);
         ty_g_ff       <= ty_f_ff;
         ty_mag_g_ff   <= ty_f_ff[31] ? ty_neg_wide[31:0] : ty_f_ff;
         ty_neg_g_ff   <= ty_f_ff[31];
         ty_zero_g_ff  <= (ty_f_ff == '0);
         drawable_g_ff <= !det_zero_f_ff && (ty_f_ff > 32'sd0);
      end
   end

   // ---------------------------------------------------------------- stage H
   // Half the screen width times (tx + ty).
   logic signed [45:0] prod_h_ff;
   logic signed [45:0] prod_h_in;
   logic signed [31:0] ty_h_ff;
   logic [31:0]        ty_mag_h_ff;
   logic               ty_neg_h_ff, ty_zero_h_ff, drawable_h_ff;

   assign prod_h_in = 46'($signed({1'b0, half_width})) * 46'(sum_g_ff);

   always_ff @(posedge clock) begin
      if (rdy_h) begin
         prod_h_ff     <= prod_h_in;
         ty_h_ff       <= ty_g_ff;
         ty_mag_h_ff   <= ty_mag_g_ff;
         ty_neg_h_ff   <= ty_neg_g_ff;
         ty_zero_h_ff  <= ty_zero_g_ff;
         drawable_h_ff <= drawable_g_ff;
      end
   end

   // ---------------------------------------------------------------- stage I
   // Magnitudes of the centre and size dividends.
   logic [63:0]        pmag_i_ff, snum_i_ff;
   logic signed [31:0] ty_i_ff;
   logic [31:0]        ty_mag_i_ff;
   logic               cneg_i_ff, ty_zero_i_ff, drawable_i_ff;
   logic signed [45:0] prod_neg;

   assign prod_neg = -prod_h_ff;

   always_ff @(posedge clock) begin
      if (rdy_i) begin
         pmag_i_ff     <= prod_h_ff[45] ? 64'(unsigned'(prod_neg)) : 64'(unsigned'(prod_h_ff));
         snum_i_ff     <= 64'(height_ff) << FRAC_BITS;
         cneg_i_ff     <= prod_h_ff[45] ^ ty_neg_h_ff;
         ty_i_ff       <= ty_h_ff;
         ty_mag_i_ff   <= ty_mag_h_ff;
         ty_zero_i_ff  <= ty_zero_h_ff;
         drawable_i_ff <= drawable_h_ff;
      end
   end

   // ---------------------------------------------------------------- stage J
   // Start remainders and saturation flags for the division by |ty|.
   logic [31:0]        remc_j_ff, lowc_j_ff, rems_j_ff, lows_j_ff, ty_mag_j_ff;
   logic signed [31:0] ty_j_ff;
   logic               ovfc_j_ff, ovfs_j_ff, cneg_j_ff, ty_zero_j_ff, drawable_j_ff;

   always_ff @(posedge clock) begin
      if (rdy_j) begin
         remc_j_ff     <= pmag_i_ff[63:32];
         lowc_j_ff     <= pmag_i_ff[31:0];
         rems_j_ff     <= snum_i_ff[63:32];
         lows_j_ff     <= snum_i_ff[31:0];
         ovfc_j_ff     <= pmag_i_ff[63:32] >= ty_mag_i_ff;
         ovfs_j_ff     <= snum_i_ff[63:32] >= ty_mag_i_ff;
         ty_mag_j_ff   <= ty_mag_i_ff;
         ty_j_ff       <= ty_i_ff;
         cneg_j_ff     <= cneg_i_ff;
         ty_zero_j_ff  <= ty_zero_i_ff;
         drawable_j_ff <= drawable_i_ff;
      end
   end

   // ---------------------------------------------------------------- screen divider
   logic [31:0] d2_quo_c, d2_quo_s;
   logic [36:0] d2_side;

   ssp_div_pipe #(
      .DEN_W  (32),
      .Q_W    (QUO_W),
      .SIDE_W (37)
   ) u_div_screen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_j_ff),
      .in_ready  (d2_in_ready),
      .in_rem_a  (remc_j_ff),
      .in_low_a  (lowc_j_ff),
      .in_rem_b  (rems_j_ff),
      .in_low_b  (lows_j_ff),
      .in_den    (ty_mag_j_ff),
      .in_side   ({cneg_j_ff, ovfc_j_ff, ovfs_j_ff, ty_zero_j_ff, drawable_j_ff,
                   ty_j_ff}),
      .out_valid (d2_out_valid),
      .out_ready (rdy_k),
      .out_quo_a (d2_quo_c),
      .out_quo_b (d2_quo_s),
      .out_side  (d2_side)
   );

   // ---------------------------------------------------------------- stage K
   // Centre column and sprite size; a zero depth puts the sprite mid-screen at full size.
   logic signed [31:0] centre_k_ff, ty_k_ff;
   logic [15:0]        size_k_ff;
   logic               drawable_k_ff;

   always_ff @(posedge clock) begin
      if (rdy_k) begin
         if (d2_side[33]) begin
            centre_k_ff <= 32'(half_width);
            size_k_ff   <= SIZE_SAT;
         end else begin
            centre_k_ff <= quo_sat(d2_quo_c, d2_side[36], d2_side[35]);
            size_k_ff   <= (d2_side[34] || (d2_quo_s[31:16] != '0)) ? SIZE_SAT
                                                                   : d2_quo_s[15:0];
         end
         ty_k_ff       <= d2_side[31:0];
         drawable_k_ff <= d2_side[32];
      end
   end

   // ---------------------------------------------------------------- stage L
   // Draw bounds clamped to the screen.
   logic [14:0]        half_size;
   logic signed [33:0] fc_wide, ec_wide, width_wide;
   logic signed [17:0] fr_wide, er_wide, height_wide, er_lim;
   logic [11:0]        fc_l_in, fr_l_in, er_l_in;
   logic signed [16:0] ec_l_in;
   logic signed [31:0] depth_ff, centre_ff;
   logic [15:0]        size_ff;
   logic [11:0]        fc_ff, fr_ff, er_ff;
   logic signed [16:0] ec_ff;
   logic               drawable_ff;

   assign half_size   = size_k_ff[15:1];
   assign fc_wide     = 34'(centre_k_ff) - 34'(half_size);
   assign ec_wide     = 34'(centre_k_ff) + 34'(half_size);
   assign width_wide  = 34'(width_ff);
   assign fr_wide     = 18'(half_height) - 18'(half_size);
   assign er_wide     = 18'(half_height) + 18'(half_size);
   assign height_wide = 18'(height_ff);
   assign er_lim      = (er_wide >= height_wide) ? 18'(height_wide - 18'sd1) : er_wide;

   always_comb begin
      priority if (fc_wide < 34'sd0) begin
         fc_l_in = '0;
      end else if (fc_wide > 34'sd4095) begin
         fc_l_in = 12'd4095;
      end else begin
         fc_l_in = fc_wide[11:0];
      end
      priority if (ec_wide >= width_wide) begin
         ec_l_in = 17'(width_wide - 34'sd1);
      end else if (ec_wide < -34'sd65536) begin
         ec_l_in = -17'sd65536;
      end else begin
         ec_l_in = ec_wide[16:0];
      end
      priority if (fr_wide < 18'sd0) begin
         fr_l_in = '0;
      end else if (fr_wide > 18'sd4095) begin
         fr_l_in = 12'd4095;
      end else begin
         fr_l_in = fr_wide[11:0];
      end
      priority if (er_lim < 18'sd0) begin
         er_l_in = '0;
      end else if (er_lim > 18'sd4095) begin
         er_l_in = 12'd4095;
      end else begin
         er_l_in = er_lim[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_l) begin
         depth_ff    <= ty_k_ff;
         centre_ff   <= centre_k_ff;
         size_ff     <= size_k_ff;
         fc_ff       <= fc_l_in;
         ec_ff       <= ec_l_in;
         fr_ff       <= fr_l_in;
         er_ff       <= er_l_in;
         drawable_ff <= drawable_k_ff;
      end
   end

   assign rsp_valid         = vld_l_ff;
   assign rsp_depth         = depth_ff;
   assign rsp_centre_column = centre_ff;
   assign rsp_sprite_size   = size_ff;
   assign rsp_first_column  = fc_ff;
   assign rsp_end_column    = ec_ff;
   assign rsp_first_row     = fr_ff;
   assign rsp_end_row       = er_ff;
   assign rsp_drawable      = drawable_ff;

   // ---------------------------------------------------------------- assertions
   // A drawable sprite always lies in front of the camera.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drawable |-> rsp_depth > 32'sd0)
      else $error("drawable sprite with non-positive depth");

   // A zero depth always gives the saturated size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_depth == '0) |-> rsp_sprite_size == SIZE_SAT)
      else $error("zero depth without saturated size");

   // With the result register empty the whole pipeline can take a beat.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while the pipeline drains freely");

   // Both divider pipelines come out of reset empty.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !d1_out_valid && !d2_out_valid)
      else $error("valid result straight after reset");

endmodule

// ===== sim/tb_sprite_screen_projection_core.sv =====
// ----------------------------------------------------------------------------
// Sprite screen projection core testbench
// Drives sprite and camera beats into the core, predicts each projection in
// wide exact arithmetic and checks every result beat in order. The screen
// size is changed between phases while the core is idle. Both sides idle at
// random, and once the receiver holds off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_sprite_screen_projection_core
   import ssp_pkg::*;
();

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 100;

   typedef struct {
      logic signed [31:0] sprite_x, sprite_y, camera_x, camera_y;
      logic signed [31:0] facing_x, facing_y, view_plane_x, view_plane_y;
   } sprite_beat_type;

   typedef struct {
      logic signed [31:0] depth;
      logic signed [31:0] centre_column;
      logic [15:0]        sprite_size;
      logic [11:0]        first_column;
      logic signed [16:0] end_column;
      logic [11:0]        first_row;
      logic [11:0]        end_row;
      logic               drawable;
   } projection_type;

   // Scoreboard: holds the screen size and the projections still owed.
   class projection_scoreboard;
      longint width_px, height_px;
      projection_type owed[$];
      int errors, beats_in, beats_out;

      function new();
         width_px  = WIDTH_RST;
         height_px = HEIGHT_RST;
      endfunction

      function automatic longint sat32(logic signed [127:0] v);
         if (v > 128'sd2147483647) return 64'sd2147483647;
         if (v < -128'sd2147483648) return -64'sd2147483648;
         return longint'(v);
      endfunction

      function automatic longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Works out the projection of one sprite beat.
      function automatic projection_type project(sprite_beat_type b);
         logic signed [127:0] sx, sy, dx, dy, px, py, det, cam;
         longint tx, ty, centre, size, half, ec, er, hw, hh;
         projection_type r;
         sx = b.sprite_x;  cam = b.camera_x;
         sx = sat32(sx - cam + (128'sd1 <<< (FRAC - 1)));
         sy = b.sprite_y;  cam = b.camera_y;
         sy = sat32(sy - cam + (128'sd1 <<< (FRAC - 1)));
         dx = b.facing_x;  dy = b.facing_y;
         px = b.view_plane_x;  py = b.view_plane_y;
         det = px * dy - dx * py;
         tx = 0;
         ty = 0;
         if (det != 0) begin
            tx = sat32(((dy * sx - dx * sy) <<< FRAC) / det);
            ty = sat32(((px * sy - py * sx) <<< FRAC) / det);
         end
         hw = width_px / 2;
         hh = height_px / 2;
         // A zero depth puts the sprite at mid screen with the largest size.
         if (ty == 0) begin
            centre = hw;
            size = 65535;
         end else begin
            centre = clip(hw * (ty + tx) / ty, -64'sd2147483648, 64'sd2147483647);
            size = (height_px <<< FRAC) / ty;
            if (size < 0) size = -size;
            if (size > 65535) size = 65535;
         end
         half = size / 2;
         ec = centre + half;
         if (ec >= width_px) ec = width_px - 1;
         if (ec < -65536) ec = -65536;
         er = hh + half;
         if (er >= height_px) er = height_px - 1;
         r.depth = ty[31:0];
         r.centre_column = centre[31:0];
         r.sprite_size = size[15:0];
         r.first_column = 12'(clip(centre - half, 0, 4095));
         r.end_column = ec[16:0];
         r.first_row = 12'(clip(hh - half, 0, 4095));
         r.end_row = 12'(clip(er, 0, 4095));
         r.drawable = (det != 0) && (ty > 0);
         return r;
      endfunction

      function void note_sprite(sprite_beat_type b);
         owed.push_back(project(b));
         beats_in++;
      endfunction

      function void check_projection(projection_type got);
         projection_type want;
         longint w[8], g[8];
         string names[8];
         beats_out++;
         if (owed.size() == 0) begin
            $display("%0t: result beat with nothing expected", $time);
            errors++;
            return;
         end
         want = owed.pop_front();
         names = '{"depth", "centre_column", "sprite_size", "first_column",
                   "end_column", "first_row", "end_row", "drawable"};
         w = '{want.depth, want.centre_column, want.sprite_size, want.first_column,
               want.end_column, want.first_row, want.end_row, want.drawable};
         g = '{got.depth, got.centre_column, got.sprite_size, got.first_column,
               got.end_column, got.first_row, got.end_row, got.drawable};
         foreach (w[i]) begin
            if (w[i] != g[i]) begin
               $display("%0t: %s mismatch, expected %0d, actual %0d",
                        $time, names[i], w[i], g[i]);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [31:0] req_sprite_x, req_sprite_y, req_camera_x, req_camera_y;
   logic signed [31:0] req_facing_x, req_facing_y, req_view_plane_x, req_view_plane_y;
   logic signed [31:0] rsp_depth, rsp_centre_column;
   logic [15:0] rsp_sprite_size;
   logic [11:0] rsp_first_column, rsp_first_row, rsp_end_row;
   logic signed [16:0] rsp_end_column;
   logic rsp_drawable;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   projection_scoreboard board = new();
   bit req_idle_on, rsp_idle_on, hold_off;
   int settings_used, quiet_cycles;

   sprite_screen_projection_core dut (.*);

   // Free-running clock; the single reset at the start is driven by the main sequence.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver: a random hold-off per beat, or one long hold when asked.
   initial begin
      int hold_n;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            hold_n = HOLD_CYCLES;
            hold_off = 0;
         end else begin
            hold_n = rsp_idle_on ? $urandom_range(0, 7) : 0;
         end
         if (hold_n > 0) begin
            rsp_stall <= 1;
            repeat (hold_n) @(negedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Monitors on both channels, and the watchdog on silent cycles.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.note_sprite('{req_sprite_x, req_sprite_y, req_camera_x, req_camera_y,
                             req_facing_x, req_facing_y, req_view_plane_x,
                             req_view_plane_y});
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_projection('{rsp_depth, rsp_centre_column, rsp_sprite_size,
                                  rsp_first_column, rsp_end_column, rsp_first_row,
                                  rsp_end_row, rsp_drawable});
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d quiet cycles", quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one sprite beat after a random gap; starts and ends on a falling edge.
   task automatic send_sprite(sprite_beat_type b);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_sprite_x <= b.sprite_x;          req_sprite_y <= b.sprite_y;
      req_camera_x <= b.camera_x;          req_camera_y <= b.camera_y;
      req_facing_x <= b.facing_x;          req_facing_y <= b.facing_y;
      req_view_plane_x <= b.view_plane_x;  req_view_plane_y <= b.view_plane_y;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Register write over the configuration port, setup then access.
   task automatic write_register(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 3'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_SCREEN_WIDTH) board.width_px = value & 32'h1FFF;
      else board.height_px = value & 32'h1FFF;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
   endtask

   // Waits on a falling edge until every owed result has come back.
   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (board.owed.size() != 0);
   endtask

   task automatic set_screen(logic [31:0] w, logic [31:0] h);
      write_register(REG_SCREEN_WIDTH, w);
      write_register(REG_SCREEN_HEIGHT, h);
      settings_used++;
   endtask

   // A plausible camera with a sprite nearby, or pure noise now and then.
   function automatic sprite_beat_type random_sprite();
      sprite_beat_type b;
      if ($urandom_range(0, 9) == 0) begin
         b = '{$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
      end else begin
         b.facing_x = int'($urandom_range(0, 262144)) - 131072;
         b.facing_y = int'($urandom_range(0, 262144)) - 131072;
         b.view_plane_x = -(b.facing_y >>> 1) + int'($urandom_range(0, 512)) - 256;
         b.view_plane_y = (b.facing_x >>> 1) + int'($urandom_range(0, 512)) - 256;
         b.camera_x = int'($urandom) >>> 6;
         b.camera_y = int'($urandom) >>> 6;
         b.sprite_x = b.camera_x + int'($urandom_range(0, 4194304)) - 2097152;
         b.sprite_y = b.camera_y + int'($urandom_range(0, 4194304)) - 2097152;
      end
      return b;
   endfunction

   initial begin
      sprite_beat_type directed[$];
      logic [31:0] widths[$], heights[$];
      reset = 1;
      req_valid = 0;
      {req_sprite_x, req_sprite_y, req_camera_x, req_camera_y} = '0;
      {req_facing_x, req_facing_y, req_view_plane_x, req_view_plane_y} = '0;
      {csr_psel, csr_penable, csr_pwrite, csr_paddr, csr_pwdata} = '0;
      req_idle_on = 0;
      rsp_idle_on = 0;
      hold_off = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed sprites: the camera looks along +y with the usual plane.
      directed = '{
         '{32'sh0002_0000, 32'sh0005_0000, 0, 0, 0, 32'sh0001_0000, 32'sh0000_A8F6, 0},
         // sprite behind the camera
         '{32'sh0002_0000, -32'sh0005_0000, 0, 0, 0, 32'sh0001_0000, 32'sh0000_A8F6, 0},
         // zero determinant with everything zero
         '{0, 0, 0, 0, 0, 0, 0, 0},
         // zero depth: sprite half a cell below the camera on both axes
         '{-32'sh8000, -32'sh8000, 0, 0, 0, 32'sh0001_0000, 32'sh0000_A8F6, 0},
         // offsets saturating both ways
         '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
           0, 32'sh0001_0000, 32'sh0001_0000, 0},
         // extreme vectors
         '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
           32'sh7FFF_FFFF, 32'sh8000_0000},
         '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
           32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF},
         // tiny vectors give huge quotients
         '{32'sh0100_0000, 32'sh0100_0000, 0, 0, 0, 1, 1, 0},
         // very close and very far sprites
         '{0, 32'sh0000_0100, 0, 0, 0, 32'sh0001_0000, 32'sh0000_A8F6, 0},
         '{0, 32'sh7000_0000, 0, 0, 0, 32'sh0001_0000, 32'sh0000_A8F6, 0},
         '{32'sh3000_0000, 32'sh0000_4000, 0, 0, 0, 32'sh0001_0000, 32'sh0000_A8F6, 0},
         '{-1, -1, -1, -1, -1, -1, -1, -1}
      };
      foreach (directed[i]) send_sprite(directed[i]);
      drain();
      settings_used = 1;

      // Screen sizes: extremes, the zero size, the largest encodable and ordinary ones.
      widths  = '{1, 4096, 0, 8191, 320, 640, 4096, 1};
      heights = '{1, 4096, 0, 8191, 200, 480, 1, 4096};
      foreach (widths[p]) begin
         set_screen(widths[p], heights[p]);
         for (int n = 0; n < 12; n++) send_sprite(directed[n % directed.size()]);
         req_idle_on = (p % 3) != 0;
         rsp_idle_on = (p % 3) != 1;
         // One phase fills the pipeline against a long receiver hold.
         if (p == 4) begin
            req_idle_on = 0;
            hold_off = 1;
         end
         for (int n = 0; n < 180; n++) send_sprite(random_sprite());
         drain();
      end
      set_screen($urandom_range(1, 4096), $urandom_range(1, 4096));
      req_idle_on = 1;
      rsp_idle_on = 1;
      for (int n = 0; n < 100; n++) send_sprite(random_sprite());
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Projected %0d sprites, checked %0d results over %0d screen sizes.",
               board.beats_in, board.beats_out, settings_used);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", board.errors, board.owed.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
